/* hw/rtl/skt_pkg.sv */
// shared types and constants for the sorted key table
`default_nettype none
package skt_pkg;

    localparam int DEPTH    = 16;
    localparam int KEY_BITS = 16;
    localparam int TAG_BITS = 16;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        FN_INSERT = 2'd0,
        FN_REMOVE = 2'd1,
        FN_FIND   = 2'd2,
        FN_READ   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_MISSING = 2'd1,
        ST_FULL    = 2'd2,
        ST_RANGE   = 2'd3
    } t_status;

    typedef struct packed {
        t_func       func;
        logic [15:0] key;
        logic [15:0] entry_tag;
        logic [3:0]  position;
    } t_in;

    typedef struct packed {
        t_status     status;
        logic [3:0]  found_position;
        logic [15:0] out_key;
        logic [15:0] out_tag;
        logic [4:0]  count;
    } t_out;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [TAG_BITS-1:0] tag;
    } t_entry;

    // broadcast to every cell
    typedef struct packed {
        logic                ins_en;
        logic                rem_en;
        logic [KEY_BITS-1:0] key;
        logic [TAG_BITS-1:0] tag;
    } t_cmd;

    // flags rippling from lower to higher positions
    typedef struct packed {
        logic ins;
        logic seen;
    } t_link;

    typedef struct packed {
        logic ins_here;
        logic first;
    } t_hit;

endpackage
`default_nettype wire

/* hw/rtl/sorted_key_table_top.sv */
// top level of the sorted key table: cell chain, entry count and result register
//
// Sorted table of up to 16 key/tag entries kept in ascending key order.
// Input channel (i_in_valid, o_in_stall, i_in_data) carries one request per
// beat: insert, remove by key, find by key or read at a position.
// Output channel (o_out_valid, i_out_stall, o_out_data) returns exactly one
// result per request, with status and the entry count after the operation.
// Every cell compares its entry against the request key at once and shifts
// with its neighbor on insert or remove.
// The result is registered and appears in the cycle after the request beat.
// Throughput: one request per cycle while the receiver does not stall, set by
// the cell chain and the result register.
// When the receiver stalls, the result register holds and the input is
// stalled until the result is taken; a new request is accepted in the same
// cycle as a held result leaves.
// Reset clears the entry count and the result valid; entry storage is not
// cleared and only positions below the count are ever read.
`default_nettype none
module sorted_key_table_top (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_stall,
    input  wire skt_pkg::t_in i_in_data,
    output logic              o_out_valid,
    input  wire logic         i_out_stall,
    output skt_pkg::t_out     o_out_data
);

    localparam int D = skt_pkg::DEPTH;

    logic [skt_pkg::CNT_W-1:0] r_count, n_count;
    logic                      r_out_valid, n_out_valid;
    skt_pkg::t_out             r_out_data, n_out_data;

    logic            accept, full, found, rd_ok;
    skt_pkg::t_cmd   cmd;
    skt_pkg::t_link  link [0:D];
    skt_pkg::t_hit   hit [D];
    skt_pkg::t_entry ent [D];
    skt_pkg::t_entry sel_ent;
    logic [D-1:0]    ins_vec, first_vec, rd_vec, sel_vec, pos_vec;
    logic [skt_pkg::IDX_W-1:0] pos;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;
    assign full       = r_count == skt_pkg::CNT_W'(D);

    always_comb begin
        cmd.key    = skt_pkg::KEY_BITS'(i_in_data.key);
        cmd.tag    = skt_pkg::TAG_BITS'(i_in_data.entry_tag);
        cmd.ins_en = accept && (i_in_data.func == skt_pkg::FN_INSERT) && !full;
        cmd.rem_en = accept && (i_in_data.func == skt_pkg::FN_REMOVE) && found;
    end

    assign link[0] = '0;

    for (genvar g = 0; g < D; g++) begin : g_cell
        skt_cell u_cell (
            .i_clk   (i_clk),
            .i_idx   (skt_pkg::IDX_W'(g)),
            .i_count (r_count),
            .i_cmd   (cmd),
            .i_left  ((g == 0) ? skt_pkg::t_entry'('0) : ent[(g == 0) ? 0 : g - 1]),
            .i_right ((g == D - 1) ? skt_pkg::t_entry'('0) : ent[(g == D - 1) ? g : g + 1]),
            .i_link  (link[g]),
            .o_link  (link[g+1]),
            .o_hit   (hit[g]),
            .o_entry (ent[g])
        );
        assign ins_vec[g]   = hit[g].ins_here;
        assign first_vec[g] = hit[g].first;
        assign rd_vec[g]    = rd_ok && (int'(i_in_data.position) == g);
    end

    assign found = |first_vec;
    assign rd_ok = int'(i_in_data.position) < int'(r_count);

    always_comb begin
        sel_vec = (i_in_data.func == skt_pkg::FN_READ) ? rd_vec : first_vec;
        pos_vec = (i_in_data.func == skt_pkg::FN_INSERT) ? ins_vec : sel_vec;
        sel_ent = '0;
        pos     = '0;
        for (int i = 0; i < D; i++) begin
            if (sel_vec[i]) begin
                sel_ent = sel_ent | ent[i];
            end
            if (pos_vec[i]) begin
                pos = pos | skt_pkg::IDX_W'(i);
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (cmd.ins_en) begin
            n_count = r_count + skt_pkg::CNT_W'(1);
        end else if (cmd.rem_en) begin
            n_count = r_count - skt_pkg::CNT_W'(1);
        end

        n_out_data                = '0;
        n_out_data.status         = skt_pkg::ST_OK;
        n_out_data.found_position = 4'(pos);
        n_out_data.count          = 5'(n_count);
        n_out_data.out_key        = 16'(sel_ent.key);
        n_out_data.out_tag        = 16'(sel_ent.tag);
        case (i_in_data.func)
            skt_pkg::FN_INSERT: begin
                n_out_data.out_key = 16'(cmd.key);
                n_out_data.out_tag = 16'(cmd.tag);
                if (full) begin
                    n_out_data.status = skt_pkg::ST_FULL;
                end
            end
            skt_pkg::FN_REMOVE, skt_pkg::FN_FIND: begin
                if (!found) begin
                    n_out_data.status = skt_pkg::ST_MISSING;
                end
            end
            skt_pkg::FN_READ: begin
                if (!rd_ok) begin
                    n_out_data.status = skt_pkg::ST_RANGE;
                end
            end
            default: begin
                n_out_data.status = skt_pkg::ST_RANGE;
            end
        endcase
        // failed requests report zero position and entry
        if (n_out_data.status != skt_pkg::ST_OK) begin
            n_out_data.found_position = '0;
            n_out_data.out_key        = '0;
            n_out_data.out_tag        = '0;
        end

        n_out_valid = r_out_valid && i_out_stall;
        if (accept) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= skt_pkg::CNT_W'(D))
        else $error("entry count beyond depth");

    a_one_ins_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !full |-> $onehot(ins_vec))
        else $error("insertion point not unique");

    a_one_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(first_vec))
        else $error("more than one first match");

    a_ins_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.ins_en |=> r_count == $past(r_count) + skt_pkg::CNT_W'(1))
        else $error("insert did not raise count");

    a_rem_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.rem_en |=> r_count == $past(r_count) - skt_pkg::CNT_W'(1))
        else $error("remove did not lower count");
`endif

endmodule
`default_nettype wire

/* hw/rtl/skt_cell.sv */
// one table position: holds an entry, compares it and shifts with its neighbors
`default_nettype none
module skt_cell (
    input  wire logic                     i_clk,
    input  wire logic [skt_pkg::IDX_W-1:0] i_idx,
    input  wire logic [skt_pkg::CNT_W-1:0] i_count,
    input  wire skt_pkg::t_cmd            i_cmd,
    input  wire skt_pkg::t_entry          i_left,
    input  wire skt_pkg::t_entry          i_right,
    input  wire skt_pkg::t_link           i_link,
    output skt_pkg::t_link                o_link,
    output skt_pkg::t_hit                 o_hit,
    output skt_pkg::t_entry               o_entry
);

    skt_pkg::t_entry r_entry, n_entry;
    logic valid, gt, at_end, match;

    always_comb begin
        valid  = skt_pkg::CNT_W'(i_idx) < i_count;
        at_end = skt_pkg::CNT_W'(i_idx) == i_count;
        gt     = valid && (r_entry.key > i_cmd.key);
        match  = valid && (r_entry.key == i_cmd.key);

        o_hit.ins_here = !i_link.ins && (gt || at_end);
        o_hit.first    = match && !i_link.seen;
        o_link.ins     = i_link.ins || gt || at_end;
        o_link.seen    = i_link.seen || match;

        n_entry = r_entry;
        if (i_cmd.ins_en) begin
            // shift up behind the insertion point
            if (i_link.ins) begin
                n_entry = i_left;
            end else if (gt || at_end) begin
                n_entry.key = i_cmd.key;
                n_entry.tag = i_cmd.tag;
            end
        end else if (i_cmd.rem_en) begin
            // the removed entry and everything above it take the right neighbor
            if (i_link.seen || match) begin
                n_entry = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule
`default_nettype wire

/* tb/sv/sorted_key_table_top_tb.sv */
// self-checking testbench for the sorted key table: directed table, random traffic, shadow table
`default_nettype none
module sorted_key_table_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import skt_pkg::*;

    localparam int RANDOM_ITEMS = 1025;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 80;
    localparam int MAX_PRINTS   = 60;

    typedef struct {
        t_in  req;
        bit   typed;
        t_out want;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_in  i_in_data;
    logic o_out_valid;
    logic i_out_stall;
    t_out o_out_data;

    sorted_key_table_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // shadow copy of the table
    logic [KEY_BITS-1:0] shadow_keys [DEPTH];
    logic [TAG_BITS-1:0] shadow_tags [DEPTH];
    int                  shadow_count;
    int                  peak_count;

    t_row plan_rows [$];
    t_out pending_results [$];
    bit   typed_next [$];
    t_out typed_want [$];

    int  err_cnt;
    int  result_cnt;
    int  cycle_cnt;
    int  func_seen [4];
    int  status_seen [4];
    bit  idle_on;
    bit  hold_req;
    int  hold_left;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_error(input string msg);
        if (err_cnt < MAX_PRINTS) begin
            $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
        end
        err_cnt++;
    endtask

    // applies one request to the shadow table and returns the result it gives
    function automatic t_out predict_request(input t_in req);
        t_out res;
        int   p;
        int   i;
        res = '0;
        res.status = ST_OK;
        case (req.func)
            FN_INSERT: begin
                if (shadow_count >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    p = 0;
                    while (p < shadow_count && shadow_keys[p] <= req.key) p++;
                    for (i = shadow_count; i > p; i--) begin
                        shadow_keys[i] = shadow_keys[i-1];
                        shadow_tags[i] = shadow_tags[i-1];
                    end
                    shadow_keys[p] = req.key;
                    shadow_tags[p] = req.entry_tag;
                    shadow_count++;
                    res.found_position = p[3:0];
                    res.out_key = req.key;
                    res.out_tag = req.entry_tag;
                end
            end
            FN_REMOVE, FN_FIND: begin
                p = shadow_count;
                for (i = shadow_count - 1; i >= 0; i--) begin
                    if (shadow_keys[i] == req.key) p = i;
                end
                if (p >= shadow_count) begin
                    res.status = ST_MISSING;
                end else begin
                    res.found_position = p[3:0];
                    res.out_key = shadow_keys[p];
                    res.out_tag = shadow_tags[p];
                    if (req.func == FN_REMOVE) begin
                        for (i = p; i + 1 < shadow_count; i++) begin
                            shadow_keys[i] = shadow_keys[i+1];
                            shadow_tags[i] = shadow_tags[i+1];
                        end
                        shadow_count--;
                    end
                end
            end
            default: begin
                if (int'(req.position) >= shadow_count) begin
                    res.status = ST_RANGE;
                end else begin
                    res.found_position = req.position;
                    res.out_key = shadow_keys[req.position];
                    res.out_tag = shadow_tags[req.position];
                end
            end
        endcase
        res.count = shadow_count[4:0];
        if (shadow_count > peak_count) peak_count = shadow_count;
        return res;
    endfunction

    // result beats are checked before request beats of the same edge are predicted
    always @(posedge i_clk) begin
        t_out want;
        t_out pred;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    report_error("result beat with nothing expected");
                end else begin
                    want = pending_results.pop_front();
                    if (o_out_data.status !== want.status)
                        report_error($sformatf("result %0d status got %0d want %0d",
                            result_cnt, o_out_data.status, want.status));
                    if (o_out_data.found_position !== want.found_position)
                        report_error($sformatf("result %0d position got %0d want %0d",
                            result_cnt, o_out_data.found_position, want.found_position));
                    if (o_out_data.out_key !== want.out_key)
                        report_error($sformatf("result %0d key got %h want %h",
                            result_cnt, o_out_data.out_key, want.out_key));
                    if (o_out_data.out_tag !== want.out_tag)
                        report_error($sformatf("result %0d tag got %h want %h",
                            result_cnt, o_out_data.out_tag, want.out_tag));
                    if (o_out_data.count !== want.count)
                        report_error($sformatf("result %0d count got %0d want %0d",
                            result_cnt, o_out_data.count, want.count));
                    status_seen[want.status]++;
                end
                result_cnt++;
            end
            if (i_in_valid && !o_in_stall) begin
                pred = predict_request(i_in_data);
                func_seen[i_in_data.func]++;
                // directed rows with a hand-written result use it in place of the shadow
                if (typed_next.size() != 0 && typed_next.pop_front()) begin
                    pending_results.push_back(typed_want.pop_front());
                end else begin
                    pending_results.push_back(pred);
                end
            end
        end
    end

    // receiver: random stall, plus one long hold-off when asked
    initial begin
        i_out_stall = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= idle_on && ($urandom_range(99) < 11);
            end
        end
    end

    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles", cycle_cnt);
        $display("TB_ERROR");
        $finish;
    end

    task automatic send_req(input t_in req, input bit typed, input t_out want);
        while (idle_on && $urandom_range(99) < 11) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        typed_next.push_back(typed);
        if (typed) typed_want.push_back(want);
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic add_row(input t_in req, input bit typed, input t_out want);
        t_row row;
        row.req = req;
        row.typed = typed;
        row.want = want;
        plan_rows.push_back(row);
    endtask

    function automatic t_in random_req(input int bias);
        t_in req;
        int  r;
        r = $urandom_range(99);
        // bias 0 leans to insert, bias 1 leans to remove
        if (bias == 0) begin
            req.func = (r < 60) ? FN_INSERT : (r < 72) ? FN_REMOVE :
                       (r < 86) ? FN_FIND : FN_READ;
        end else begin
            req.func = (r < 15) ? FN_INSERT : (r < 65) ? FN_REMOVE :
                       (r < 82) ? FN_FIND : FN_READ;
        end
        r = $urandom_range(99);
        if (shadow_count > 0 && r < 50) begin
            req.key = shadow_keys[$urandom_range(shadow_count - 1)];
        end else if (r < 70) begin
            case ($urandom_range(3))
                0: req.key = 16'h0000;
                1: req.key = 16'hFFFF;
                2: req.key = 16'h8000;
                default: req.key = 16'h7FFF;
            endcase
        end else begin
            req.key = 16'($urandom);
        end
        req.entry_tag = 16'($urandom);
        req.position = 4'($urandom_range(15));
        return req;
    endfunction

    initial begin
        t_in  req;
        t_out none;
        int   i;
        int   bias;

        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        hold_req   = 1'b0;
        idle_on    = 1'b1;
        err_cnt    = 0;
        result_cnt = 0;
        shadow_count = 0;
        peak_count = 0;
        none = '0;
        for (i = 0; i < 4; i++) begin
            func_seen[i] = 0;
            status_seen[i] = 0;
        end

        // empty table: every lookup fails
        add_row('{FN_FIND,   16'h1234, 16'h0000, 4'd0},  1'b1,
                '{ST_MISSING, 4'd0, 16'h0000, 16'h0000, 5'd0});
        add_row('{FN_READ,   16'h0000, 16'h0000, 4'd0},  1'b1,
                '{ST_RANGE,   4'd0, 16'h0000, 16'h0000, 5'd0});
        add_row('{FN_REMOVE, 16'hFFFF, 16'hFFFF, 4'd15}, 1'b1,
                '{ST_MISSING, 4'd0, 16'h0000, 16'h0000, 5'd0});
        // key and tag extremes
        add_row('{FN_INSERT, 16'hFFFF, 16'h0000, 4'd0},  1'b1,
                '{ST_OK,      4'd0, 16'hFFFF, 16'h0000, 5'd1});
        add_row('{FN_INSERT, 16'h0000, 16'hFFFF, 4'd15}, 1'b1,
                '{ST_OK,      4'd0, 16'h0000, 16'hFFFF, 5'd2});
        add_row('{FN_READ,   16'h0000, 16'h0000, 4'd15}, 1'b1,
                '{ST_RANGE,   4'd0, 16'h0000, 16'h0000, 5'd2});
        // equal key goes after the existing one, find and remove take the first
        add_row('{FN_INSERT, 16'hFFFF, 16'h1234, 4'd0},  1'b1,
                '{ST_OK,      4'd2, 16'hFFFF, 16'h1234, 5'd3});
        add_row('{FN_FIND,   16'hFFFF, 16'h0000, 4'd0},  1'b1,
                '{ST_OK,      4'd1, 16'hFFFF, 16'h0000, 5'd3});
        add_row('{FN_REMOVE, 16'hFFFF, 16'h0000, 4'd0},  1'b1,
                '{ST_OK,      4'd1, 16'hFFFF, 16'h0000, 5'd2});
        // fill the table in mixed order
        for (i = 0; i < 14; i++) begin
            req.func = FN_INSERT;
            req.key = 16'((i * 16'h2493) ^ 16'h5A5A);
            req.entry_tag = ~req.key;
            req.position = 4'(i);
            add_row(req, 1'b0, none);
        end
        add_row('{FN_INSERT, 16'h4242, 16'h2424, 4'd0},  1'b1,
                '{ST_FULL,    4'd0, 16'h0000, 16'h0000, 5'd16});
        add_row('{FN_READ,   16'h0000, 16'h0000, 4'd15}, 1'b0, none);

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan_rows[k]) begin
            send_req(plan_rows[k].req, plan_rows[k].typed, plan_rows[k].want);
        end

        bias = 1;
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 60 == 0) bias = 1 - bias;
            if (i == 300) hold_req = 1'b1;
            if (i == 500) wait_drained();
            idle_on = !(i >= 600 && i < 850);
            send_req(random_req(bias), 1'b0, none);
        end

        wait_drained();
        repeat (4) @(posedge i_clk);
        if (pending_results.size() != 0)
            report_error($sformatf("%0d results never arrived", pending_results.size()));

        $display("covered %0d requests: insert %0d, remove %0d, find %0d, read %0d",
                 func_seen[FN_INSERT] + func_seen[FN_REMOVE] + func_seen[FN_FIND]
                 + func_seen[FN_READ], func_seen[FN_INSERT], func_seen[FN_REMOVE],
                 func_seen[FN_FIND], func_seen[FN_READ]);
        $display("statuses ok %0d, missing %0d, full %0d, range %0d; peak fill %0d, errors %0d",
                 status_seen[ST_OK], status_seen[ST_MISSING], status_seen[ST_FULL],
                 status_seen[ST_RANGE], peak_count, err_cnt);
        if (err_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire
